// ===== design/hkrb_pkg.sv =====
// Shared types, constants and key tables for the boot-keyboard report builder.
package hkrb_pkg;

  localparam int unsigned SLOT_COUNT_DEF = 6;

  localparam logic [7:0] RAW_BASE   = 8'd136;
  localparam logic [7:0] SHIFT_MARK = 8'h80;
  localparam logic [7:0] LEFT_SHIFT = 8'h02;
  localparam logic [7:0] RIGHT_ALT  = 8'h40;
  localparam logic [7:0] USAGE_MASK = 8'h7F;

  typedef enum logic [1:0] {
    KIND_PRESS       = 2'd0,
    KIND_RELEASE     = 2'd1,
    KIND_RELEASE_ALL = 2'd2,
    KIND_WRITE       = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_UNMAPPED = 2'd1,
    STAT_NO_SLOT  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_PRESS   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2
  } slot_op_e;

  typedef struct packed {
    logic       start;
    slot_op_e   op;
    logic [7:0] key;
  } slot_cmd_t;

  typedef struct packed {
    logic done;
    logic full;
  } slot_rsp_t;

  typedef struct packed {
    logic       unmapped;
    logic [7:0] key;
    logic [7:0] mod_bits;
  } keymap_t;

  // ASCII to usage; bit 7 marks a shifted character
  localparam logic [7:0] CHAR_ROM [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2c, 8'hb4, 8'hb3, 8'h20, 8'h21, 8'had, 8'h24, 8'hb1,
    8'hb0, 8'h30, 8'h25, 8'h1e, 8'h36, 8'h38, 8'h37, 8'haf,
    8'ha7, 8'h9e, 8'h9f, 8'ha0, 8'ha1, 8'ha2, 8'ha3, 8'ha4,
    8'ha5, 8'ha6, 8'hb7, 8'h35, 8'h36, 8'h2d, 8'h37, 8'hb6,
    8'h1f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
    8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
    8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
    8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'h23, 8'hb8,
    8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
    8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
    8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
  };

  // one bit per ASCII code: character needs AltGr
  localparam logic [127:0] ALTGR_MAP =
    {32'h78000001, 32'h78000001, 32'h50000458, 32'h00000000};

endpackage

// ===== design/hkrb_if.sv =====
// Request and report channel interfaces.
interface hkrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] key_code;

  modport source (output valid, kind, key_code, input ready);
  modport sink   (input valid, kind, key_code, output ready);
endinterface

interface hkrb_out_if;
  logic       valid;
  logic       ready;
  logic       report_sent;
  logic [1:0] status;
  logic [7:0] modifier_bits;
  logic [7:0] slot_zero;
  logic [7:0] slot_one;
  logic [7:0] slot_two;
  logic [7:0] slot_three;
  logic [7:0] slot_four;
  logic [7:0] slot_five;
  logic       last_result;

  modport source (output valid, report_sent, status, modifier_bits, slot_zero, slot_one,
                  slot_two, slot_three, slot_four, slot_five, last_result, input ready);
  modport sink   (input valid, report_sent, status, modifier_bits, slot_zero, slot_one,
                  slot_two, slot_three, slot_four, slot_five, last_result, output ready);
endinterface

// ===== design/hkrb_keymap.sv =====
// Key code decode: raw usage, modifier code or ASCII through the layout ROM.
module hkrb_keymap (
  input  logic [7:0]       code_i,
  output hkrb_pkg::keymap_t map_o
);

  logic       is_raw;
  logic       is_mod;
  logic [7:0] entry;

  assign is_raw = (code_i >= hkrb_pkg::RAW_BASE);
  assign is_mod = code_i[7] && !is_raw;
  assign entry  = hkrb_pkg::CHAR_ROM[code_i[6:0]];

  always_comb begin
    map_o.unmapped = 1'b0;
    if (is_raw) begin
      map_o.key      = code_i - hkrb_pkg::RAW_BASE;
      map_o.mod_bits = 8'h00;
    end else if (is_mod) begin
      map_o.key      = 8'h00;
      map_o.mod_bits = 8'h01 << code_i[2:0];
    end else begin
      map_o.unmapped = (entry == 8'h00);
      map_o.key      = entry & hkrb_pkg::USAGE_MASK;
      map_o.mod_bits = (entry[7] ? hkrb_pkg::LEFT_SHIFT : 8'h00) |
                       (hkrb_pkg::ALTGR_MAP[code_i[6:0]] ? hkrb_pkg::RIGHT_ALT : 8'h00);
    end
  end

endmodule

// ===== design/hkrb_slot_scan.sv =====
// Key slot store with one shared compare unit stepping through the slots.
module hkrb_slot_scan #(
  parameter int unsigned SLOT_COUNT = hkrb_pkg::SLOT_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hkrb_pkg::slot_cmd_t   cmd_i,
  output hkrb_pkg::slot_rsp_t   rsp_o,
  output logic [7:0]            slots_o [SLOT_COUNT]
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [7:0]          slot_q [SLOT_COUNT];
  logic                busy_q;
  logic [IdxW-1:0]     idx_q;
  hkrb_pkg::slot_op_e  op_q;
  logic [7:0]          key_q;
  logic                hit_q;
  logic                found_q;
  logic [IdxW-1:0]     first_q;

  logic [7:0]      cur;
  logic            last;
  logic            match;
  logic            empty;
  logic            hit_all;
  logic            found_all;
  logic [IdxW-1:0] tgt;

  assign cur       = slot_q[idx_q];
  assign last      = (idx_q == IdxW'(SLOT_COUNT - 1));
  assign match     = (cur == key_q);
  assign empty     = (cur == 8'h00);
  assign hit_all   = hit_q || match;
  assign found_all = found_q || empty;
  // first empty slot seen so far, else the one under the compare now
  assign tgt       = found_q ? first_q : idx_q;

  assign rsp_o.done = busy_q && last;
  assign rsp_o.full = (op_q == hkrb_pkg::OP_PRESS) && !hit_all && !found_all;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_out
    assign slots_o[g] = slot_q[g];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_q[i] <= 8'h00;
      busy_q  <= 1'b0;
      idx_q   <= '0;
      op_q    <= hkrb_pkg::OP_PRESS;
      key_q   <= 8'h00;
      hit_q   <= 1'b0;
      found_q <= 1'b0;
      first_q <= '0;
    end else if (!busy_q) begin
      if (cmd_i.start) begin
        busy_q  <= 1'b1;
        idx_q   <= '0;
        op_q    <= cmd_i.op;
        key_q   <= cmd_i.key;
        hit_q   <= 1'b0;
        found_q <= 1'b0;
      end
    end else begin
      unique case (op_q)
        hkrb_pkg::OP_PRESS: begin
          if (match) hit_q <= 1'b1;
          if (empty && !found_q) begin
            found_q <= 1'b1;
            first_q <= idx_q;
          end
          if (last && !hit_all && found_all) slot_q[tgt] <= key_q;
        end
        hkrb_pkg::OP_RELEASE: begin
          if (key_q != 8'h00 && match) slot_q[idx_q] <= 8'h00;
        end
        hkrb_pkg::OP_CLEAR: begin
          slot_q[idx_q] <= 8'h00;
        end
        default: ;
      endcase
      if (last) busy_q <= 1'b0;
      else      idx_q  <= idx_q + IdxW'(1);
    end
  end

endmodule

// ===== design/hid_keyboard_report_builder_core.sv =====
// Boot-keyboard report builder: sequencer, modifier byte and report register.
//
//   channel   dir  handshake      payload
//   in_req_i  in   valid/ready    kind, key_code
//   rpt_o     out  valid/ready    report_sent, status, modifier_bits, slot_*, last_result
//
// A request is taken only while the sequencer is idle. Each press, release or
// release-all walks the key slots through one compare unit, one slot a cycle;
// a write walks them twice, press then release, and gives two reports.
// Unmapped characters skip the walk. A stalled report register holds the sequencer
// in its emit step. Reset clears modifiers, slots and all control.
module hid_keyboard_report_builder_core #(
  parameter int unsigned SLOT_COUNT = hkrb_pkg::SLOT_COUNT_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  hkrb_in_if.sink    in_req_i,
  hkrb_out_if.source rpt_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_WAIT,
    S_EMIT
  } state_e;

  state_e              state_q;
  hkrb_pkg::kind_e     kind_q;
  logic [7:0]          code_q;
  logic                rel_phase_q;
  hkrb_pkg::status_e   status_q;
  logic [7:0]          mod_q;
  logic                out_valid_q;

  hkrb_pkg::keymap_t   map;
  hkrb_pkg::slot_cmd_t cmd;
  hkrb_pkg::slot_rsp_t rsp;
  logic [7:0]          slots [SLOT_COUNT];
  logic [7:0]          shown [6];
  logic                in_fire;
  logic                load;
  logic                is_last;

  hkrb_keymap u_keymap (
    .code_i (code_q),
    .map_o  (map)
  );

  hkrb_slot_scan #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .rsp_o   (rsp),
    .slots_o (slots)
  );

  for (genvar g = 0; g < 6; g++) begin : g_show
    if (g < SLOT_COUNT) begin : g_on
      assign shown[g] = slots[g];
    end else begin : g_off
      assign shown[g] = 8'h00;
    end
  end

  assign in_req_i.ready = (state_q == S_IDLE);
  assign in_fire        = in_req_i.valid && in_req_i.ready;
  assign load           = (state_q == S_EMIT) && (!out_valid_q || rpt_o.ready);
  assign is_last        = !(kind_q == hkrb_pkg::KIND_WRITE && !rel_phase_q);

  always_comb begin
    cmd.start = 1'b0;
    cmd.op    = hkrb_pkg::OP_PRESS;
    cmd.key   = map.key;
    if (state_q == S_PREP) begin
      if (kind_q == hkrb_pkg::KIND_RELEASE_ALL) begin
        cmd.start = 1'b1;
        cmd.op    = hkrb_pkg::OP_CLEAR;
      end else if (!map.unmapped) begin
        cmd.start = 1'b1;
        cmd.op    = rel_phase_q ? hkrb_pkg::OP_RELEASE : hkrb_pkg::OP_PRESS;
      end
    end
  end

  assign rpt_o.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= hkrb_pkg::KIND_PRESS;
      code_q      <= 8'h00;
      rel_phase_q <= 1'b0;
      status_q    <= hkrb_pkg::STAT_OK;
      mod_q       <= 8'h00;
      out_valid_q <= 1'b0;
      rpt_o.report_sent   <= 1'b0;
      rpt_o.status        <= hkrb_pkg::STAT_OK;
      rpt_o.modifier_bits <= 8'h00;
      rpt_o.slot_zero     <= 8'h00;
      rpt_o.slot_one      <= 8'h00;
      rpt_o.slot_two      <= 8'h00;
      rpt_o.slot_three    <= 8'h00;
      rpt_o.slot_four     <= 8'h00;
      rpt_o.slot_five     <= 8'h00;
      rpt_o.last_result   <= 1'b0;
    end else begin
      if (rpt_o.ready && !load) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            kind_q      <= hkrb_pkg::kind_e'(in_req_i.kind);
            code_q      <= in_req_i.key_code;
            rel_phase_q <= (in_req_i.kind == hkrb_pkg::KIND_RELEASE);
            state_q     <= S_PREP;
          end
        end
        S_PREP: begin
          if (kind_q == hkrb_pkg::KIND_RELEASE_ALL) begin
            mod_q    <= 8'h00;
            status_q <= hkrb_pkg::STAT_OK;
            state_q  <= S_WAIT;
          end else if (map.unmapped) begin
            status_q <= hkrb_pkg::STAT_UNMAPPED;
            state_q  <= S_EMIT;
          end else begin
            // modifier bits change even when the press later finds no slot
            mod_q   <= rel_phase_q ? (mod_q & ~map.mod_bits) : (mod_q | map.mod_bits);
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (rsp.done) begin
            status_q <= rsp.full ? hkrb_pkg::STAT_NO_SLOT : hkrb_pkg::STAT_OK;
            state_q  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load) begin
            out_valid_q         <= 1'b1;
            rpt_o.report_sent   <= (status_q == hkrb_pkg::STAT_OK);
            rpt_o.status        <= status_q;
            rpt_o.modifier_bits <= mod_q;
            rpt_o.slot_zero     <= shown[0];
            rpt_o.slot_one      <= shown[1];
            rpt_o.slot_two      <= shown[2];
            rpt_o.slot_three    <= shown[3];
            rpt_o.slot_four     <= shown[4];
            rpt_o.slot_five     <= shown[5];
            rpt_o.last_result   <= is_last;
            if (is_last) begin
              state_q <= S_IDLE;
            end else begin
              rel_phase_q <= 1'b1;
              state_q     <= S_PREP;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_sent_iff_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rpt_o.valid |-> (rpt_o.report_sent == (rpt_o.status == hkrb_pkg::STAT_OK)))
    else $error("report_sent disagrees with status");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> (state_q == S_WAIT))
    else $error("slot scan finished outside the wait step");

  a_accept_to_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_PREP))
    else $error("accepted request did not start decode");

  a_write_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && !is_last) |=> (state_q == S_PREP && rel_phase_q))
    else $error("write did not continue with its release");

endmodule

// ===== bench/hid_keyboard_report_builder_core_tb.sv =====
// Self-checking testbench for the boot-keyboard report builder core.
module hid_keyboard_report_builder_core_tb;

  localparam int unsigned SLOTS = 6;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES = 4 * SLOTS + 16;

  localparam logic [7:0] RAW_OFFSET = 8'd136;
  localparam logic [7:0] MOD_OFFSET = 8'd128;
  localparam logic [7:0] SHIFT_BIT  = 8'h02;
  localparam logic [7:0] ALTGR_BIT  = 8'h40;

  // Czech QWERTY: ASCII to usage, bit 7 set when the character is shifted
  localparam logic [7:0] ASCII_USAGE [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h2c, 8'hb4, 8'hb3, 8'h20, 8'h21, 8'had, 8'h24, 8'hb1,
    8'hb0, 8'h30, 8'h25, 8'h1e, 8'h36, 8'h38, 8'h37, 8'haf,
    8'ha7, 8'h9e, 8'h9f, 8'ha0, 8'ha1, 8'ha2, 8'ha3, 8'ha4,
    8'ha5, 8'ha6, 8'hb7, 8'h35, 8'h36, 8'h2d, 8'h37, 8'hb6,
    8'h1f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
    8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
    8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
    8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'h23, 8'hb8,
    8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
    8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
    8'h1b, 8'h1c, 8'h1d, 8'haf, 8'hb1, 8'hb0, 8'hb5, 8'h00
  };

  // bit n set: ASCII code n is typed with AltGr
  localparam logic [127:0] ALTGR_CHARS =
    {32'h78000001, 32'h78000001, 32'h50000458, 32'h00000000};

  typedef struct packed {
    logic              sent;
    hkrb_pkg::status_e status;
    logic [7:0]        mods;
    logic [5:0][7:0]   slots;
    logic              last;
  } report_t;

  logic clk_i;
  logic rst_ni;

  hkrb_in_if  req_if ();
  hkrb_out_if rpt_if ();

  hid_keyboard_report_builder_core #(
    .SLOT_COUNT (SLOTS)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req_i (req_if),
    .rpt_o    (rpt_if)
  );

  // predicted keyboard state
  logic [7:0] kb_mods;
  logic [7:0] kb_slots [SLOTS];

  report_t pending_reports [$];

  bit          send_idle;
  bit          recv_idle;
  int unsigned long_hold;
  int unsigned items_sent;
  int unsigned kind_count [4];
  int unsigned reports_checked;
  int unsigned full_hits;
  int unsigned unmapped_hits;
  int unsigned mismatch_count;
  int unsigned error_count;
  int unsigned quiet_cycles;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic report_t snapshot(input hkrb_pkg::status_e st, input logic last);
    report_t r;
    r.sent   = (st == hkrb_pkg::STAT_OK);
    r.status = st;
    r.mods   = kb_mods;
    for (int i = 0; i < 6; i++) r.slots[i] = (i < SLOTS) ? kb_slots[i] : 8'h00;
    r.last   = last;
    return r;
  endfunction

  function automatic hkrb_pkg::status_e kb_press(input logic [7:0] code);
    logic [7:0] usage;
    logic [7:0] key;
    bit         present;
    present = 1'b0;
    if (code >= RAW_OFFSET) begin
      key = code - RAW_OFFSET;
    end else if (code >= MOD_OFFSET) begin
      kb_mods[code[2:0]] = 1'b1;
      key = 8'h00;
    end else begin
      usage = ASCII_USAGE[code[6:0]];
      if (usage == 8'h00) return hkrb_pkg::STAT_UNMAPPED;
      if (usage[7]) kb_mods = kb_mods | SHIFT_BIT;
      key = {1'b0, usage[6:0]};
      if (ALTGR_CHARS[code[6:0]]) kb_mods = kb_mods | ALTGR_BIT;
    end
    // a zero key counts as present while any slot is free
    for (int i = 0; i < SLOTS; i++) if (kb_slots[i] == key) present = 1'b1;
    if (present) return hkrb_pkg::STAT_OK;
    for (int i = 0; i < SLOTS; i++) begin
      if (kb_slots[i] == 8'h00) begin
        kb_slots[i] = key;
        return hkrb_pkg::STAT_OK;
      end
    end
    return hkrb_pkg::STAT_NO_SLOT;
  endfunction

  function automatic hkrb_pkg::status_e kb_release(input logic [7:0] code);
    logic [7:0] usage;
    logic [7:0] key;
    if (code >= RAW_OFFSET) begin
      key = code - RAW_OFFSET;
    end else if (code >= MOD_OFFSET) begin
      kb_mods[code[2:0]] = 1'b0;
      key = 8'h00;
    end else begin
      usage = ASCII_USAGE[code[6:0]];
      if (usage == 8'h00) return hkrb_pkg::STAT_UNMAPPED;
      if (usage[7]) kb_mods = kb_mods & ~SHIFT_BIT;
      key = {1'b0, usage[6:0]};
      if (ALTGR_CHARS[code[6:0]]) kb_mods = kb_mods & ~ALTGR_BIT;
    end
    for (int i = 0; i < SLOTS; i++)
      if (key != 8'h00 && kb_slots[i] == key) kb_slots[i] = 8'h00;
    return hkrb_pkg::STAT_OK;
  endfunction

  function automatic void predict_reports(input hkrb_pkg::kind_e kind,
                                          input logic [7:0] code);
    hkrb_pkg::status_e st;
    case (kind)
      hkrb_pkg::KIND_PRESS: begin
        st = kb_press(code);
        pending_reports.push_back(snapshot(st, 1'b1));
      end
      hkrb_pkg::KIND_RELEASE: begin
        st = kb_release(code);
        pending_reports.push_back(snapshot(st, 1'b1));
      end
      hkrb_pkg::KIND_RELEASE_ALL: begin
        kb_mods = 8'h00;
        for (int i = 0; i < SLOTS; i++) kb_slots[i] = 8'h00;
        pending_reports.push_back(snapshot(hkrb_pkg::STAT_OK, 1'b1));
      end
      default: begin
        st = kb_press(code);
        pending_reports.push_back(snapshot(st, 1'b0));
        st = kb_release(code);
        pending_reports.push_back(snapshot(st, 1'b1));
      end
    endcase
  endfunction

  // one request: optional gap, then hold valid until the core takes it
  task automatic send_request(input hkrb_pkg::kind_e kind, input logic [7:0] code);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid    = 1'b1;
    req_if.kind     = kind;
    req_if.key_code = code;
    do @(posedge clk_i); while (!req_if.ready);
    predict_reports(kind, code);
    items_sent++;
    kind_count[kind]++;
  endtask

  function automatic logic [7:0] pick_key_code();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(32, 126));
      4:          return 8'($urandom_range(0, 127));
      5:          return MOD_OFFSET + 8'($urandom_range(0, 7));
      6:          return RAW_OFFSET + 8'($urandom_range(0, 31));
      7:          return 8'($urandom_range(0, 255));
      default:    return 8'($urandom_range(97, 100));
    endcase
  endfunction

  function automatic hkrb_pkg::kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 8) return hkrb_pkg::KIND_PRESS;
    if (r < 14) return hkrb_pkg::KIND_RELEASE;
    if (r < 18) return hkrb_pkg::KIND_WRITE;
    return hkrb_pkg::KIND_RELEASE_ALL;
  endfunction

  task automatic run_directed();
    send_request(hkrb_pkg::KIND_PRESS, 8'h00);         // unmapped control char
    send_request(hkrb_pkg::KIND_RELEASE, 8'h7F);       // unmapped DEL
    send_request(hkrb_pkg::KIND_PRESS, "a");
    send_request(hkrb_pkg::KIND_PRESS, "A");           // shifted, same usage as 'a'
    send_request(hkrb_pkg::KIND_PRESS, "@");           // AltGr
    send_request(hkrb_pkg::KIND_PRESS, MOD_OFFSET);
    send_request(hkrb_pkg::KIND_PRESS, MOD_OFFSET + 8'd7);
    send_request(hkrb_pkg::KIND_PRESS, RAW_OFFSET);    // raw zero usage
    send_request(hkrb_pkg::KIND_PRESS, 8'hFF);
    send_request(hkrb_pkg::KIND_PRESS, "a");           // already held
    send_request(hkrb_pkg::KIND_PRESS, 8'h0A);
    send_request(hkrb_pkg::KIND_PRESS, 8'h09);
    send_request(hkrb_pkg::KIND_PRESS, 8'h08);         // fills the last slot
    send_request(hkrb_pkg::KIND_PRESS, "~");           // full, shift and AltGr stay set
    send_request(hkrb_pkg::KIND_PRESS, RAW_OFFSET);    // zero usage on a full report
    send_request(hkrb_pkg::KIND_PRESS, MOD_OFFSET);    // modifier on a full report
    send_request(hkrb_pkg::KIND_PRESS, "a");           // present key on a full report
    send_request(hkrb_pkg::KIND_RELEASE, "~");
    send_request(hkrb_pkg::KIND_RELEASE, MOD_OFFSET + 8'd7);
    send_request(hkrb_pkg::KIND_RELEASE, "a");
    send_request(hkrb_pkg::KIND_WRITE, "Z");
    send_request(hkrb_pkg::KIND_WRITE, 8'h00);
    send_request(hkrb_pkg::KIND_RELEASE_ALL, 8'hFF);
    send_request(hkrb_pkg::KIND_WRITE, 8'hFF);
    send_request(hkrb_pkg::KIND_RELEASE, RAW_OFFSET);
  endtask

  // press a handful of keys, then let them go in random order
  task automatic run_typing(input int unsigned target);
    logic [7:0]  held [$];
    logic [7:0]  code;
    int unsigned n;
    int unsigned idx;
    while (items_sent < target) begin
      held.delete();
      n = $urandom_range(1, 8);
      repeat (n) begin
        code = pick_key_code();
        held.push_back(code);
        send_request(($urandom_range(0, 5) == 0) ? hkrb_pkg::KIND_WRITE
                                                 : hkrb_pkg::KIND_PRESS, code);
      end
      while (held.size() > 0) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(hkrb_pkg::KIND_RELEASE_ALL, 8'($urandom));
          held.delete();
        end else begin
          idx = $urandom_range(0, held.size() - 1);
          send_request(hkrb_pkg::KIND_RELEASE, held[idx]);
          held.delete(idx);
        end
      end
    end
  endtask

  task automatic run_random_mix(input int unsigned target);
    while (items_sent < target) send_request(pick_kind(), pick_key_code());
  endtask

  task automatic run_back_to_back(input int unsigned target);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    run_typing(target);
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // receiver stops for a long stretch while requests keep coming
  task automatic run_backpressure(input int unsigned target);
    send_idle = 1'b0;
    long_hold = 300;
    run_typing(items_sent + 40);
    send_idle = 1'b1;
    long_hold = 200;
    run_random_mix(target);
  endtask

  task automatic finish_run();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending_reports.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_reports.size() > 0) begin
      $display("%0d expected reports never arrived", pending_reports.size());
      error_count += pending_reports.size();
    end
    $display("%0d requests (press %0d, release %0d, release-all %0d, write %0d), %0d reports",
             items_sent, kind_count[hkrb_pkg::KIND_PRESS],
             kind_count[hkrb_pkg::KIND_RELEASE], kind_count[hkrb_pkg::KIND_RELEASE_ALL],
             kind_count[hkrb_pkg::KIND_WRITE], reports_checked);
    $display("full-report hits %0d, unmapped hits %0d, failures %0d",
             full_hits, unmapped_hits, error_count);
    if (error_count == 0) begin
      $display("[hid_keyboard_report_builder_core] OK");
    end else begin
      $display("[hid_keyboard_report_builder_core] ERROR");
    end
    $finish;
  endtask

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.kind     = hkrb_pkg::KIND_PRESS;
    req_if.key_code = 8'h00;
    rpt_if.ready    = 1'b0;
    send_idle       = 1'b1;
    recv_idle       = 1'b1;
    long_hold       = 0;
    kb_mods         = 8'h00;
    for (int i = 0; i < SLOTS; i++) kb_slots[i] = 8'h00;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    run_directed();
    run_typing(700);
    run_random_mix(1050);
    run_back_to_back(1250);
    run_backpressure(1350);
    finish_run();
  end

  // report sink: random stalls, plus an occasional long hold-off
  initial begin
    int unsigned stall;
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold > 0) begin
        hold = long_hold;
        long_hold = 0;
        rpt_if.ready = 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      stall = recv_idle ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        rpt_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rpt_if.ready = 1'b1;
      do @(posedge clk_i); while (!rpt_if.valid);
    end
  end

  always @(posedge clk_i) begin : check_reports
    report_t got;
    report_t want;
    bit      bad;
    if (rst_ni && rpt_if.valid && rpt_if.ready) begin
      got.sent     = rpt_if.report_sent;
      got.status   = hkrb_pkg::status_e'(rpt_if.status);
      got.mods     = rpt_if.modifier_bits;
      got.slots[0] = rpt_if.slot_zero;
      got.slots[1] = rpt_if.slot_one;
      got.slots[2] = rpt_if.slot_two;
      got.slots[3] = rpt_if.slot_three;
      got.slots[4] = rpt_if.slot_four;
      got.slots[5] = rpt_if.slot_five;
      got.last     = rpt_if.last_result;
      reports_checked++;
      if (pending_reports.size() == 0) begin
        error_count++;
        if (mismatch_count < 10)
          $display("unexpected report: sent=%0d st=%0d mod=%02h slots=%h last=%0d",
                   got.sent, got.status, got.mods, got.slots, got.last);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        if (want.status == hkrb_pkg::STAT_NO_SLOT) full_hits++;
        if (want.status == hkrb_pkg::STAT_UNMAPPED) unmapped_hits++;
        bad = 1'b0;
        if (got.sent !== want.sent) bad = 1'b1;
        if (got.status !== want.status) bad = 1'b1;
        if (got.mods !== want.mods) bad = 1'b1;
        for (int i = 0; i < 6; i++) if (got.slots[i] !== want.slots[i]) bad = 1'b1;
        if (got.last !== want.last) bad = 1'b1;
        if (bad) begin
          error_count++;
          if (mismatch_count < 10) begin
            $display("report mismatch at %0t:", $realtime);
            $display("  exp sent=%0d st=%0d mod=%02h slots=%h last=%0d",
                     want.sent, want.status, want.mods, want.slots, want.last);
            $display("  got sent=%0d st=%0d mod=%02h slots=%h last=%0d",
                     got.sent, got.status, got.mods, got.slots, got.last);
          end
          mismatch_count++;
        end
      end
    end
  end

  // no handshake on either channel for too long means the core hung
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rpt_if.valid && rpt_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no progress for %0d cycles, %0d reports outstanding",
               quiet_cycles, pending_reports.size());
      $display("[hid_keyboard_report_builder_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial quiet_cycles = 0;

endmodule
